### rtl/lsch_pkg.sv
// shared types and constants for the lottery scheduler
`default_nettype none

package lsch_pkg;

  // request and response field widths
  localparam int OPCODE_W = 1;
  localparam int PROC_W   = 4;
  localparam int STATE_W  = 2;
  localparam int TICKET_W = 16;
  localparam int RANDOM_W = 32;
  localparam int TOTAL_W  = 20;
  localparam int MCNT_W   = $clog2(RANDOM_W);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE   = 1'b0,
    OP_RESCHED = 1'b1
  } opcode_e;

  typedef enum logic [STATE_W-1:0] {
    RS_FREE    = 2'd0,
    RS_RUNNING = 2'd1,
    RS_READY   = 2'd2,
    RS_BLOCKED = 2'd3
  } run_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_MOD,
    ST_PICK,
    ST_DEMOTE,
    ST_PROMOTE,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic wr_entry;
    logic walk_clr;
    logic sum_walk;
    logic latch_total;
    logic mod_step;
    logic pick_walk;
    logic demote;
    logic promote;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_write;
    logic walk_done;
    logic total_zero;
    logic mod_last;
    logic found;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/lsch_req_if.sv
// request channel of the lottery scheduler
`default_nettype none

interface lsch_req_if;
  logic                           valid;
  logic                           ready;
  logic [lsch_pkg::OPCODE_W-1:0]  opcode;
  logic [lsch_pkg::PROC_W-1:0]    proc_index;
  logic [lsch_pkg::STATE_W-1:0]   run_state;
  logic [lsch_pkg::TICKET_W-1:0]  ticket_count;
  logic [lsch_pkg::RANDOM_W-1:0]  random_word;

  modport source (
    output valid, opcode, proc_index, run_state, ticket_count, random_word,
    input  ready
  );

  modport sink (
    input  valid, opcode, proc_index, run_state, ticket_count, random_word,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lsch_rsp_if.sv
// response channel of the lottery scheduler
`default_nettype none

interface lsch_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          winner_found;
  logic [lsch_pkg::PROC_W-1:0]   winner_index;
  logic [lsch_pkg::TOTAL_W-1:0]  ticket_sum;

  modport source (
    output valid, winner_found, winner_index, ticket_sum,
    input  ready
  );

  modport sink (
    input  valid, winner_found, winner_index, ticket_sum,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lsch_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module lsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/lsch_ctrl.sv
// sequencing state machine of the lottery scheduler
`default_nettype none

module lsch_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  input  wire logic [lsch_pkg::OPCODE_W-1:0] req_opcode_i,
  output logic                              req_ready_o,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i,
  input  wire lsch_pkg::dp_sts_t            sts_i,
  output lsch_pkg::dp_cmd_t                 cmd_o
);

  lsch_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsch_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      lsch_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.walk_clr = 1'b1;
          state_d = (req_opcode_i == lsch_pkg::OP_WRITE) ? lsch_pkg::ST_WRITE
                                                         : lsch_pkg::ST_SUM;
        end
      end
      lsch_pkg::ST_WRITE: begin
        cmd_o.wr_entry = 1'b1;
        state_d        = lsch_pkg::ST_SUM;
      end
      lsch_pkg::ST_SUM: begin
        cmd_o.sum_walk = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.latch_total = 1'b1;
          state_d = (sts_i.is_write || sts_i.total_zero) ? lsch_pkg::ST_FINISH
                                                         : lsch_pkg::ST_MOD;
        end
      end
      lsch_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          cmd_o.walk_clr = 1'b1;
          state_d        = lsch_pkg::ST_PICK;
        end
      end
      lsch_pkg::ST_PICK: begin
        cmd_o.pick_walk = 1'b1;
        if (sts_i.found) begin
          state_d = lsch_pkg::ST_DEMOTE;
        end
      end
      lsch_pkg::ST_DEMOTE: begin
        cmd_o.demote = 1'b1;
        state_d      = lsch_pkg::ST_PROMOTE;
      end
      lsch_pkg::ST_PROMOTE: begin
        cmd_o.promote = 1'b1;
        state_d       = lsch_pkg::ST_FINISH;
      end
      lsch_pkg::ST_FINISH: begin
        // wait for the output register to drain
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = lsch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsch_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.emit | (out_valid_q & ~rsp_ready_i);
  assign rsp_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q != lsch_pkg::ST_IDLE))
    else $error("accepted request left controller idle");

  a_rsp_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q == lsch_pkg::ST_FINISH))
    else $error("response raised outside finish state");

  a_promote_after_demote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsch_pkg::ST_PROMOTE) |-> ($past(state_q) == lsch_pkg::ST_DEMOTE))
    else $error("promote not preceded by demote");
`endif

endmodule

`default_nettype wire

### rtl/lsch_dp.sv
// datapath: process table, ticket walks, modulo reduction and result register
`default_nettype none

module lsch_dp #(
  parameter int NUM_PROCS   = 16,
  parameter int TICKET_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lsch_pkg::dp_cmd_t             cmd_i,
  output lsch_pkg::dp_sts_t                  sts_o,
  input  wire logic [lsch_pkg::OPCODE_W-1:0] req_opcode_i,
  input  wire logic [lsch_pkg::PROC_W-1:0]   req_proc_index_i,
  input  wire logic [lsch_pkg::STATE_W-1:0]  req_run_state_i,
  input  wire logic [lsch_pkg::TICKET_W-1:0] req_ticket_count_i,
  input  wire logic [lsch_pkg::RANDOM_W-1:0] req_random_word_i,
  output logic                               rsp_winner_found_o,
  output logic      [lsch_pkg::PROC_W-1:0]   rsp_winner_index_o,
  output logic      [lsch_pkg::TOTAL_W-1:0]  rsp_ticket_sum_o
);

  localparam int PW      = lsch_pkg::PROC_W;
  localparam int SW      = lsch_pkg::STATE_W;
  localparam int RW      = lsch_pkg::RANDOM_W;
  localparam int TW      = lsch_pkg::TOTAL_W;
  localparam int MW      = lsch_pkg::MCNT_W;
  localparam int IDX_W   = $clog2(NUM_PROCS);
  localparam int CNT_W   = $clog2(NUM_PROCS + 1);
  localparam int TKW     = (TICKET_BITS < lsch_pkg::TICKET_W) ? TICKET_BITS
                                                              : lsch_pkg::TICKET_W;
  localparam int SUM_W   = TKW + $clog2(NUM_PROCS);
  localparam int ENTRY_W = SW + TKW;
  localparam int CMP_W   = (SUM_W > TW) ? SUM_W : TW;

  // captured request
  logic                op_write_q;
  logic [PW-1:0]       proc_q;
  logic [SW-1:0]       state_in_q;
  logic [TKW-1:0]      tk_in_q;
  logic [RW-1:0]       rnd_q;

  // table and walk
  logic [NUM_PROCS-1:0] vld_q;
  logic                 rd_vld_q;
  logic                 rd_pend_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SUM_W-1:0]     acc_q;
  logic [SUM_W-1:0]     total_q;
  logic [SUM_W-1:0]     rem_q;
  logic [MW-1:0]        mod_cnt_q;
  logic                 found_q;
  logic [IDX_W-1:0]     win_idx_q;
  logic [TKW-1:0]       win_tk_q;
  logic                 demoted_q;
  logic [TKW-1:0]       cur_tk_q;
  logic [IDX_W-1:0]     run_idx_q;
  logic                 res_found_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [ENTRY_W-1:0]   ent;
  logic [SW-1:0]        ent_state;
  logic [TKW-1:0]       ent_tk;
  logic                 ent_elig;
  logic [SUM_W-1:0]     acc_next;
  logic                 walking;
  logic                 issue;
  logic                 walk_done;
  logic                 hit;
  logic                 write_ok;
  logic [SUM_W:0]       mod_t;
  logic [SUM_W-1:0]     rem_next;
  logic [CMP_W-1:0]     total_wide;
  logic [TW-1:0]        total_sat;

  lsch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_PROCS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entries never written read as free with no tickets
  assign ent       = rd_vld_q ? ram_rdata : '0;
  assign ent_state = ent[ENTRY_W-1 -: SW];
  assign ent_tk    = ent[TKW-1:0];
  assign ent_elig  = (ent_state == lsch_pkg::RS_RUNNING) ||
                     (ent_state == lsch_pkg::RS_READY);
  assign acc_next  = acc_q + (ent_elig ? SUM_W'(ent_tk) : '0);

  assign walking   = cmd_i.sum_walk | cmd_i.pick_walk;
  assign issue     = walking && (cnt_q != CNT_W'(NUM_PROCS));
  assign ram_raddr = cnt_q[IDX_W-1:0];
  assign walk_done = (cnt_q == CNT_W'(NUM_PROCS)) && !rd_pend_q;
  assign hit       = cmd_i.pick_walk && rd_pend_q && !found_q && (rem_q < acc_next);

  assign write_ok  = 32'(proc_q) < 32'(NUM_PROCS);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(proc_q);
    ram_wdata = {state_in_q, tk_in_q};
    if (cmd_i.wr_entry && write_ok) begin
      ram_we = 1'b1;
    end else if (cmd_i.demote && demoted_q && (win_idx_q != run_idx_q)) begin
      ram_we    = 1'b1;
      ram_waddr = run_idx_q;
      ram_wdata = {lsch_pkg::RS_READY, cur_tk_q};
    end else if (cmd_i.promote) begin
      ram_we    = 1'b1;
      ram_waddr = win_idx_q;
      ram_wdata = {lsch_pkg::RS_RUNNING, win_tk_q};
    end
  end

  // restoring remainder, one dividend bit per step
  assign mod_t    = {rem_q, rnd_q[RW-1]};
  assign rem_next = (mod_t >= {1'b0, total_q}) ? SUM_W'(mod_t - {1'b0, total_q})
                                               : SUM_W'(mod_t);

  assign total_wide = CMP_W'(total_q);
  assign total_sat  = (total_wide > CMP_W'(lsch_pkg::TOTAL_MAX)) ? lsch_pkg::TOTAL_MAX
                                                                 : TW'(total_wide);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      run_idx_q   <= '0;
      res_found_q <= 1'b0;
      mod_cnt_q   <= '0;
    end else begin
      rd_vld_q <= vld_q[ram_raddr];
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (cmd_i.load) begin
        res_found_q <= 1'b0;
      end
      if (cmd_i.walk_clr) begin
        cnt_q     <= '0;
        rd_pend_q <= 1'b0;
        found_q   <= 1'b0;
      end else begin
        rd_pend_q <= issue;
        if (issue) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.latch_total) begin
        mod_cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        mod_cnt_q <= mod_cnt_q + MW'(1);
      end
      if (cmd_i.promote) begin
        run_idx_q   <= win_idx_q;
        res_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_write_q <= (req_opcode_i == lsch_pkg::OP_WRITE);
      proc_q     <= req_proc_index_i;
      state_in_q <= req_run_state_i;
      tk_in_q    <= req_ticket_count_i[TKW-1:0];
    end
    rd_idx_q <= ram_raddr;
    if (cmd_i.walk_clr) begin
      acc_q <= '0;
    end else if (rd_pend_q && (cmd_i.sum_walk || (cmd_i.pick_walk && !found_q))) begin
      acc_q <= acc_next;
    end
    // the entry at the running index is seen once during the sum walk
    if (cmd_i.sum_walk && rd_pend_q && (rd_idx_q == run_idx_q)) begin
      demoted_q <= (ent_state == lsch_pkg::RS_RUNNING);
      cur_tk_q  <= ent_tk;
    end
    if (hit) begin
      win_idx_q <= rd_idx_q;
      win_tk_q  <= ent_tk;
    end
    if (cmd_i.latch_total) begin
      total_q <= acc_q;
      rem_q   <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_next;
    end
    if (cmd_i.load) begin
      rnd_q <= req_random_word_i;
    end else if (cmd_i.mod_step) begin
      rnd_q <= {rnd_q[RW-2:0], 1'b0};
    end
    if (cmd_i.emit) begin
      rsp_winner_found_o <= res_found_q;
      rsp_winner_index_o <= PW'(run_idx_q);
      rsp_ticket_sum_o   <= total_sat;
    end
  end

  assign sts_o.is_write   = op_write_q;
  assign sts_o.walk_done  = walk_done;
  assign sts_o.total_zero = (acc_q == '0);
  assign sts_o.mod_last   = (mod_cnt_q == MW'(RW - 1));
  assign sts_o.found      = found_q;

`ifndef NO_ASSERTIONS
  a_draw_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick_walk |-> (rem_q < total_q))
    else $error("draw not below ticket total");

  a_pick_finds_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pick_walk && walk_done) |-> found_q)
    else $error("winner walk ended without a winner");

  a_run_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(run_idx_q) < 32'(NUM_PROCS))
    else $error("running index out of table range");
`endif

endmodule

`default_nettype wire

### rtl/lottery_scheduler_top.sv
// top level of the lottery scheduler
`default_nettype none

// Lottery scheduler over a table of NUM_PROCS process entries, each with a
// run state and a ticket count, held in a small ram with one valid bit per
// entry so the table reads as all free right after reset. A write request
// updates one entry; a reschedule request draws random_word modulo the total
// of ready and running tickets and makes the drawn entry running. One request
// is in work at a time and one response comes back per request; the next
// request is taken while the previous response waits in the output register.
// A write is followed by the summing walk, which reads one table entry per
// cycle. A reschedule with a nonzero total runs two table walks plus a
// 32-step restoring remainder unit, the second walk stopping at the winner;
// with a zero total it ends after the sum. A response sink that holds a
// waiting response back holds the controller in its finish state.

module lottery_scheduler_top #(
  parameter int NUM_PROCS   = 16,
  parameter int TICKET_BITS = 16
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  lsch_req_if.sink    req_i,
  lsch_rsp_if.source  rsp_o
);

  lsch_pkg::dp_cmd_t cmd;
  lsch_pkg::dp_sts_t sts;

  lsch_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  lsch_dp #(
    .NUM_PROCS   (NUM_PROCS),
    .TICKET_BITS (TICKET_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .req_opcode_i       (req_i.opcode),
    .req_proc_index_i   (req_i.proc_index),
    .req_run_state_i    (req_i.run_state),
    .req_ticket_count_i (req_i.ticket_count),
    .req_random_word_i  (req_i.random_word),
    .rsp_winner_found_o (rsp_o.winner_found),
    .rsp_winner_index_o (rsp_o.winner_index),
    .rsp_ticket_sum_o   (rsp_o.ticket_sum)
  );

endmodule

`default_nettype wire

### sim/lottery_scheduler_top_tb.sv
// testbench for the lottery scheduler: predicts each response and checks it in order
`default_nettype none

module lottery_scheduler_top_tb;

  localparam int NPROC       = 16;
  localparam int ITEMS       = 900;
  localparam int CALM_AFTER  = 800;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 100;
  localparam int PW          = lsch_pkg::PROC_W;
  localparam int TKW         = lsch_pkg::TICKET_W;
  localparam int RNW         = lsch_pkg::RANDOM_W;
  localparam int TOTW        = lsch_pkg::TOTAL_W;

  typedef struct {
    lsch_pkg::opcode_e     op;
    logic [PW-1:0]         idx;
    lsch_pkg::run_state_e  st;
    logic [TKW-1:0]        tickets;
    logic [RNW-1:0]        rnd;
  } sched_req_t;

  typedef struct {
    logic                  found;
    logic [PW-1:0]         idx;
    logic [TOTW-1:0]       total;
  } grant_t;

  // tracks the process table and the grants that are owed by the block
  class lottery_book;
    lsch_pkg::run_state_e slot_state[NPROC];
    logic [TKW-1:0]       slot_tickets[NPROC];
    logic [PW-1:0]        cur_idx;
    grant_t               pending_grants[$];
    int unsigned          failures;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i]   = lsch_pkg::RS_FREE;
        slot_tickets[i] = '0;
      end
      cur_idx  = '0;
      failures = 0;
    endfunction

    function int unsigned eligible_sum();
      int unsigned sum;
      sum = 0;
      foreach (slot_state[i])
        if (slot_state[i] == lsch_pkg::RS_RUNNING || slot_state[i] == lsch_pkg::RS_READY)
          sum += slot_tickets[i];
      return sum;
    endfunction

    function logic [TOTW-1:0] clip_total(int unsigned sum);
      return (sum > lsch_pkg::TOTAL_MAX) ? lsch_pkg::TOTAL_MAX : sum[TOTW-1:0];
    endfunction

    function void note_request(sched_req_t r);
      grant_t              g;
      int unsigned         total;
      int unsigned         draw;
      int unsigned         acc;
      logic [PW-1:0]       winner;
      bit                  demoted;
      bit                  hit;
      if (r.op == lsch_pkg::OP_WRITE) begin
        slot_state[r.idx]   = r.st;
        slot_tickets[r.idx] = r.tickets;
        g.found = 1'b0;
        g.idx   = cur_idx;
        g.total = clip_total(eligible_sum());
      end else begin
        demoted = 1'b0;
        if (slot_state[cur_idx] == lsch_pkg::RS_RUNNING) begin
          slot_state[cur_idx] = lsch_pkg::RS_READY;
          demoted = 1'b1;
        end
        total = eligible_sum();
        if (total == 0) begin
          // nothing to draw from: undo the demotion, no grant
          if (demoted) slot_state[cur_idx] = lsch_pkg::RS_RUNNING;
          g.found = 1'b0;
          g.idx   = cur_idx;
          g.total = '0;
        end else begin
          draw   = r.rnd % total;
          acc    = 0;
          hit    = 1'b0;
          winner = cur_idx;
          for (int i = 0; i < NPROC; i++) begin
            if (slot_state[i] == lsch_pkg::RS_RUNNING || slot_state[i] == lsch_pkg::RS_READY)
              acc += slot_tickets[i];
            if (!hit && draw < acc) begin
              winner = i[PW-1:0];
              hit    = 1'b1;
            end
          end
          slot_state[winner] = lsch_pkg::RS_RUNNING;
          cur_idx = winner;
          g.found = 1'b1;
          g.idx   = winner;
          g.total = clip_total(total);
        end
      end
      pending_grants.push_back(g);
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected response: found=%0b idx=%0d total=%0d",
                   got.found, got.idx, got.total);
        return;
      end
      want = pending_grants.pop_front();
      if (got.found !== want.found || got.idx !== want.idx || got.total !== want.total) begin
        failures++;
        if (failures <= 10)
          $display({"response mismatch: expected found=%0b idx=%0d total=%0d, ",
                    "got found=%0b idx=%0d total=%0d"},
                   want.found, want.idx, want.total, got.found, got.idx, got.total);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   sent;
  int   cycle_cnt;

  lottery_book book = new();

  lsch_req_if req_bus ();
  lsch_rsp_if rsp_bus ();

  lottery_scheduler_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one request per call, accepted at the edge where valid and ready are both high
  task automatic send_request(lsch_pkg::opcode_e op, logic [PW-1:0] idx,
                              lsch_pkg::run_state_e st, logic [TKW-1:0] tickets,
                              logic [RNW-1:0] rnd);
    sched_req_t r;
    r = '{op, idx, st, tickets, rnd};
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.opcode       <= op;
    req_bus.proc_index   <= idx;
    req_bus.run_state    <= st;
    req_bus.ticket_count <= tickets;
    req_bus.random_word  <= rnd;
    @(negedge clk);
    while (!req_bus.ready) @(negedge clk);
    @(posedge clk);
    book.note_request(r);
    sent++;
    calm = (sent >= CALM_AFTER);
  endtask

  task automatic put_entry(int idx, lsch_pkg::run_state_e st, logic [TKW-1:0] tickets);
    send_request(lsch_pkg::OP_WRITE, idx[PW-1:0], st, tickets, $urandom);
  endtask

  task automatic reschedule(logic [RNW-1:0] rnd);
    send_request(lsch_pkg::OP_RESCHED, PW'($urandom_range(0, NPROC - 1)),
                 lsch_pkg::run_state_e'($urandom_range(0, 3)), TKW'($urandom), rnd);
  endtask

  function automatic logic [TKW-1:0] pick_tickets();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return TKW'($urandom_range(1, 8));
      default: return TKW'($urandom);
    endcase
  endfunction

  function automatic logic [RNW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 3);
      1:       return '1;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // mostly eligible states so draws have something to pick from
  function automatic lsch_pkg::run_state_e pick_state();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return lsch_pkg::RS_READY;
      4, 5:       return lsch_pkg::RS_RUNNING;
      6:          return lsch_pkg::RS_FREE;
      default:    return lsch_pkg::RS_BLOCKED;
    endcase
  endfunction

  // often hit the running entry so the demotion step sees odd states
  function automatic int pick_slot();
    if ($urandom_range(0, 3) == 0) return int'(book.cur_idx);
    return int'($urandom_range(0, NPROC - 1));
  endfunction

  initial begin
    int pick;
    rst_n                <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.opcode       <= lsch_pkg::OP_WRITE;
    req_bus.proc_index   <= '0;
    req_bus.run_state    <= lsch_pkg::RS_FREE;
    req_bus.ticket_count <= '0;
    req_bus.random_word  <= '0;
    sent = 0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, then a running entry with no tickets
    reschedule('1);
    put_entry(0, lsch_pkg::RS_RUNNING, '0);
    reschedule(32'h0000_0007);
    put_entry(15, lsch_pkg::RS_READY, 16'hFFFF);
    put_entry(3, lsch_pkg::RS_RUNNING, 16'h0001);
    put_entry(7, lsch_pkg::RS_BLOCKED, 16'h5555);
    put_entry(9, lsch_pkg::RS_FREE, 16'hAAAA);
    reschedule('0);
    reschedule('1);
    // second running entry written directly
    put_entry(5, lsch_pkg::RS_RUNNING, 16'h8000);
    reschedule(32'hAAAA_AAAA);
    reschedule(32'h5555_5555);
    // current entry blocked before the draw
    put_entry(int'(book.cur_idx), lsch_pkg::RS_BLOCKED, 16'h0100);
    reschedule(32'h1234_5678);
    put_entry(int'(book.cur_idx), lsch_pkg::RS_FREE, '0);
    reschedule(32'h0001_0000);
    put_entry(15, lsch_pkg::RS_READY, '0);
    put_entry(5, lsch_pkg::RS_READY, 16'h7FFF);
    reschedule(32'h8000_0000);

    while (sent < ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        repeat ($urandom_range(1, 4)) put_entry(pick_slot(), pick_state(), pick_tickets());
        repeat ($urandom_range(1, 3)) reschedule(pick_word());
      end else if (pick < 14) begin
        // whole table eligible, often at the largest total
        for (int i = 0; i < NPROC; i++)
          put_entry(i, $urandom_range(0, 1) ? lsch_pkg::RS_READY : lsch_pkg::RS_RUNNING,
                    $urandom_range(0, 1) ? 16'hFFFF : pick_tickets());
        repeat ($urandom_range(1, 3)) reschedule(pick_word());
      end else if (pick == 14) begin
        // drain to a zero total
        for (int i = 0; i < NPROC; i++)
          put_entry(i, $urandom_range(0, 1) ? lsch_pkg::RS_FREE : lsch_pkg::RS_BLOCKED,
                    TKW'($urandom));
        reschedule(pick_word());
      end else begin
        send_request(lsch_pkg::opcode_e'($urandom_range(0, 1)),
                     PW'($urandom_range(0, NPROC - 1)),
                     lsch_pkg::run_state_e'($urandom_range(0, 3)), TKW'($urandom),
                     $urandom);
      end
    end
    req_bus.valid <= 1'b0;

    while (book.pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (book.failures == 0 && book.pending_grants.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // response side stalls in short bursts
  initial begin
    int hold;
    hold = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        rsp_bus.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_bus.ready <= 1'b0;
        hold = $urandom_range(0, 4);
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // handshake signals are stable at the falling edge
  always @(negedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready)
      book.check_grant('{rsp_bus.winner_found, rsp_bus.winner_index, rsp_bus.ticket_sum});
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
